>>> hw/rtl/pdmc_pkg.sv
package pdmc_pkg;

   localparam int unsigned MEAS_W    = 16;
   localparam int unsigned GAIN_W    = 16;
   localparam int unsigned DIV_W     = 16;
   localparam int unsigned TERM_W    = 18;
   localparam int unsigned SUM_W     = 34;
   localparam int unsigned QUO_W     = 32;
   localparam int unsigned MAG_W     = 33;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 33;
   localparam int unsigned DIV_STEPS = QUO_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_POINT     = 3'd0,
      CSR_PROP_GAIN     = 3'd1,
      CSR_DERIV_GAIN    = 3'd2,
      CSR_DIVISOR       = 3'd3,
      CSR_MAX_MAGNITUDE = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_D,
      ST_ADD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> hw/rtl/pd_drive_magnitude_clamp.sv
// pd controller with the derivative acting on the measurement. each request beat carries
// one signed sample; the block forms error = set_point - |measurement| and
// rate = measurement - previous measurement, then
// raw = (prop_gain * error + deriv_gain * rate) / divisor, truncated toward zero, with
// 8 fraction bits (gains are q8.8). the response beat gives raw and min(|raw|, max_magnitude).
// a divisor of 0 is taken as 1. from request acceptance to the response being offered an
// item runs both products through the shared 16x18 multiplier and the accumulate, then a
// divider start, the bit-serial restoring divider and a finish step that waits for room in
// the response register. one item is in flight at a time; req_ready is high only while the
// sequencer is idle, and a finished response waits in its own output register so the next
// request can be taken before the response is collected. registers are to be written
// through the csr port only while the block is idle; the block itself does not enforce this.
// csr_ready is always high and indexes beyond the list are ignored.
module pd_drive_magnitude_clamp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pdmc_pkg::MEAS_W-1:0]  req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [pdmc_pkg::MAG_W-1:0]   rsp_drive_magnitude,
   output logic signed [pdmc_pkg::SUM_W-1:0]   rsp_raw_drive,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [pdmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [pdmc_pkg::CSR_DAT_W-1:0] csr_data
);

   // configuration registers
   logic signed [pdmc_pkg::MEAS_W-1:0] sp_ff;
   logic signed [pdmc_pkg::GAIN_W-1:0] pgain_ff;
   logic signed [pdmc_pkg::GAIN_W-1:0] dgain_ff;
   logic        [pdmc_pkg::DIV_W-1:0]  divisor_ff;
   logic        [pdmc_pkg::MAG_W-1:0]  max_ff;

   // sample state and working registers
   logic signed [pdmc_pkg::MEAS_W-1:0] prev_ff;
   logic signed [pdmc_pkg::TERM_W-1:0] err_ff;
   logic signed [pdmc_pkg::TERM_W-1:0] rate_ff;
   logic signed [pdmc_pkg::SUM_W-1:0]  prod_ff;
   logic signed [pdmc_pkg::SUM_W-1:0]  acc_ff;
   logic                               neg_ff;

   // response register
   logic                               rsp_valid_ff;
   logic        [pdmc_pkg::MAG_W-1:0]  rsp_mag_ff;
   logic signed [pdmc_pkg::SUM_W-1:0]  rsp_raw_ff;

   pdmc_pkg::state_type state_ff, state_in;

   // sequencer outputs
   logic take_req;
   logic div_start;
   logic rsp_load;

   assign csr_ready = 1'b1;

   // -------- configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff      <= '0;
         pgain_ff   <= '0;
         dgain_ff   <= '0;
         divisor_ff <= pdmc_pkg::DIV_W'(1);
         max_ff     <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            pdmc_pkg::CSR_SET_POINT:     sp_ff      <= csr_data[pdmc_pkg::MEAS_W-1:0];
            pdmc_pkg::CSR_PROP_GAIN:     pgain_ff   <= csr_data[pdmc_pkg::GAIN_W-1:0];
            pdmc_pkg::CSR_DERIV_GAIN:    dgain_ff   <= csr_data[pdmc_pkg::GAIN_W-1:0];
            pdmc_pkg::CSR_DIVISOR:       divisor_ff <= csr_data[pdmc_pkg::DIV_W-1:0];
            pdmc_pkg::CSR_MAX_MAGNITUDE: max_ff     <= csr_data[pdmc_pkg::MAG_W-1:0];
            default: ;
         endcase
      end
   end

   // -------- error and rate terms, formed as the beat is taken
   logic signed [pdmc_pkg::MEAS_W:0]   meas_ext;
   logic signed [pdmc_pkg::MEAS_W:0]   meas_abs;
   logic signed [pdmc_pkg::TERM_W-1:0] err_in;
   logic signed [pdmc_pkg::TERM_W-1:0] rate_in;

   assign meas_ext = {req_measurement[pdmc_pkg::MEAS_W-1], req_measurement};
   // |-32768| still fits the 17 bit signed form
   assign meas_abs = meas_ext[pdmc_pkg::MEAS_W] ? -meas_ext : meas_ext;
   assign err_in   = {{2{sp_ff[pdmc_pkg::MEAS_W-1]}}, sp_ff}
                   - {meas_abs[pdmc_pkg::MEAS_W], meas_abs};
   assign rate_in  = {{2{req_measurement[pdmc_pkg::MEAS_W-1]}}, req_measurement}
                   - {{2{prev_ff[pdmc_pkg::MEAS_W-1]}}, prev_ff};

   // -------- shared multiplier, proportional term first then derivative term
   logic signed [pdmc_pkg::GAIN_W-1:0] mul_a;
   logic signed [pdmc_pkg::TERM_W-1:0] mul_b;
   logic signed [pdmc_pkg::SUM_W-1:0]  mul_out;

   assign mul_a   = (state_ff == pdmc_pkg::ST_MUL_P) ? pgain_ff : dgain_ff;
   assign mul_b   = (state_ff == pdmc_pkg::ST_MUL_P) ? err_ff : rate_ff;
   // 16 x 18 signed gives exactly the 34 bit sum width
   assign mul_out = mul_a * mul_b;

   // -------- divider feed: magnitude of the sum, below 2^32
   logic signed [pdmc_pkg::SUM_W-1:0] acc_abs;
   logic        [pdmc_pkg::DIV_W-1:0] divisor_eff;
   logic        [pdmc_pkg::QUO_W-1:0] quotient;
   pdmc_pkg::div_status_type          div_status;

   assign acc_abs     = acc_ff[pdmc_pkg::SUM_W-1] ? -acc_ff : acc_ff;
   // a zero divisor passes the sum through undivided
   assign divisor_eff = (divisor_ff == '0) ? pdmc_pkg::DIV_W'(1) : divisor_ff;

   pdmc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_abs[pdmc_pkg::QUO_W-1:0]),
      .divisor  (divisor_eff),
      .quotient (quotient),
      .status   (div_status)
   );

   // -------- sign restore and clamp
   logic signed [pdmc_pkg::SUM_W-1:0] quo_ext;
   logic signed [pdmc_pkg::SUM_W-1:0] raw_val;
   logic        [pdmc_pkg::MAG_W-1:0] mag_val;
   logic        [pdmc_pkg::MAG_W-1:0] mag_clamped;

   assign quo_ext     = {2'b00, quotient};
   assign raw_val     = neg_ff ? -quo_ext : quo_ext;
   assign mag_val     = {1'b0, quotient};
   assign mag_clamped = (mag_val > max_ff) ? max_ff : mag_val;

   // -------- sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdmc_pkg::ST_IDLE:      if (req_valid) state_in = pdmc_pkg::ST_MUL_P;
         pdmc_pkg::ST_MUL_P:     state_in = pdmc_pkg::ST_MUL_D;
         pdmc_pkg::ST_MUL_D:     state_in = pdmc_pkg::ST_ADD;
         pdmc_pkg::ST_ADD:       state_in = pdmc_pkg::ST_DIV_START;
         pdmc_pkg::ST_DIV_START: state_in = pdmc_pkg::ST_DIV_WAIT;
         pdmc_pkg::ST_DIV_WAIT:  if (div_status.done) state_in = pdmc_pkg::ST_FINISH;
         pdmc_pkg::ST_FINISH:    if (!rsp_valid_ff || rsp_ready) state_in = pdmc_pkg::ST_IDLE;
         default:                state_in = pdmc_pkg::ST_IDLE;
      endcase
   end

   // -------- sequencer: outputs
   always_comb begin
      take_req  = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         pdmc_pkg::ST_IDLE:      take_req  = 1'b1;
         pdmc_pkg::ST_DIV_START: div_start = 1'b1;
         pdmc_pkg::ST_FINISH:    rsp_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign req_ready = take_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdmc_pkg::ST_IDLE;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (take_req && req_valid) prev_ff <= req_measurement;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (take_req && req_valid) begin
         err_ff  <= err_in;
         rate_ff <= rate_in;
      end
      case (state_ff)
         pdmc_pkg::ST_MUL_P: prod_ff <= mul_out;
         pdmc_pkg::ST_MUL_D: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_out;
         end
         pdmc_pkg::ST_ADD:       acc_ff <= acc_ff + prod_ff;
         pdmc_pkg::ST_DIV_START: neg_ff <= acc_ff[pdmc_pkg::SUM_W-1];
         default: ;
      endcase
      if (rsp_load) begin
         rsp_mag_ff <= mag_clamped;
         rsp_raw_ff <= raw_val;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_magnitude = rsp_mag_ff;
   assign rsp_raw_drive       = rsp_raw_ff;

   // -------- checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == pdmc_pkg::ST_DIV_WAIT)
      else $error("divider finished outside the wait state");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pdmc_pkg::ST_FINISH)
      else $error("response raised outside the finish state");

endmodule

>>> hw/rtl/pdmc_divider.sv
module pdmc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pdmc_pkg::QUO_W-1:0]     dividend,
   input  logic [pdmc_pkg::DIV_W-1:0]     divisor,
   output logic [pdmc_pkg::QUO_W-1:0]     quotient,
   output pdmc_pkg::div_status_type       status
);

   logic [pdmc_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [pdmc_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [pdmc_pkg::DIV_W-1:0]     dsr_ff, dsr_in;
   logic [pdmc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [pdmc_pkg::DIV_W:0]   shifted;
   logic [pdmc_pkg::DIV_W+1:0] trial;

   // one restoring step: shift in the next dividend bit, try the subtract
   assign shifted = {rem_ff, quo_ff[pdmc_pkg::QUO_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[pdmc_pkg::DIV_W+1]) begin
            rem_in = trial[pdmc_pkg::DIV_W-1:0];
            quo_in = {quo_ff[pdmc_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[pdmc_pkg::DIV_W-1:0];
            quo_in = {quo_ff[pdmc_pkg::QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pdmc_pkg::DIV_CNT_W'(pdmc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> dv/tb.sv
module tb;

   // watchdog: cycles in a row with no beat on any channel before the run is abandoned
   localparam int unsigned STALL_LIMIT   = 2000;
   // idle time after the last item has come through the multiplier and the serial divider
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned PHASES        = 8;
   localparam int unsigned PHASE_ITEMS   = 229;
   localparam int unsigned IDLE_PCT      = 35;
   localparam int unsigned CALM_PHASE    = 3;

   // register slots past the end of the list, writes there must be dropped
   localparam logic [pdmc_pkg::CSR_IDX_W-1:0] CSR_PAST_END  = 3'd5;
   localparam logic [pdmc_pkg::CSR_IDX_W-1:0] CSR_LAST_SLOT = '1;
   localparam logic [pdmc_pkg::MAG_W-1:0]     MAG_ALL_ONES  = '1;

   typedef struct packed {
      logic        [pdmc_pkg::MAG_W-1:0] mag;
      logic signed [pdmc_pkg::SUM_W-1:0] raw;
   } drive_beat_type;

   typedef enum bit {
      ROW_CSR,
      ROW_SAMPLE
   } row_kind_type;

   typedef struct {
      row_kind_type                       kind;
      logic [pdmc_pkg::CSR_IDX_W-1:0]     idx;
      logic [pdmc_pkg::CSR_DAT_W-1:0]     data;
      logic signed [pdmc_pkg::MEAS_W-1:0] meas;
      bit                                 typed;
      drive_beat_type                     want;
   } stim_row_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic signed [pdmc_pkg::MEAS_W-1:0]      req_measurement = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic        [pdmc_pkg::MAG_W-1:0]       rsp_drive_magnitude;
   logic signed [pdmc_pkg::SUM_W-1:0]       rsp_raw_drive;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic        [pdmc_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic        [pdmc_pkg::CSR_DAT_W-1:0]   csr_data = '0;

   // typed expectation travelling alongside the request beat
   bit                                      beat_typed = 1'b0;
   drive_beat_type                          beat_want = '0;

   // own copy of the control law state and settings
   logic signed [pdmc_pkg::MEAS_W-1:0]      cfg_set_point;
   logic signed [pdmc_pkg::GAIN_W-1:0]      cfg_prop_gain;
   logic signed [pdmc_pkg::GAIN_W-1:0]      cfg_deriv_gain;
   logic        [pdmc_pkg::DIV_W-1:0]       cfg_divisor;
   logic        [pdmc_pkg::MAG_W-1:0]       cfg_max_mag;
   logic signed [pdmc_pkg::MEAS_W-1:0]      last_meas;

   drive_beat_type                          drive_due_q[$];
   stim_row_type                            dir_rows[$];
   int unsigned                             fail_count = 0;
   int unsigned                             quiet_cycles = 0;
   bit                                      calm = 1'b0;

   pd_drive_magnitude_clamp dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_measurement     (req_measurement),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_magnitude (rsp_drive_magnitude),
      .rsp_raw_drive       (rsp_raw_drive),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // control law: error on the magnitude, rate on the raw measurement
   // ---------------------------------------------------------------------------
   function automatic drive_beat_type predict_drive(logic signed [pdmc_pkg::MEAS_W-1:0] meas);
      longint         m;
      longint         mag_in;
      longint         err;
      longint         rate;
      longint         sum;
      longint         dvs;
      longint         quo;
      longint         amag;
      drive_beat_type b;
      m      = longint'(meas);
      mag_in = (m < 0) ? -m : m;
      err    = longint'(cfg_set_point) - mag_in;
      rate   = m - longint'(last_meas);
      sum    = longint'(cfg_prop_gain) * err + longint'(cfg_deriv_gain) * rate;
      // a zero divisor lets the sum through undivided
      dvs    = (cfg_divisor == '0) ? 64'sd1 : longint'(cfg_divisor);
      // sv signed division already truncates toward zero
      quo    = sum / dvs;
      amag   = (quo < 0) ? -quo : quo;
      b.mag  = (amag > longint'(cfg_max_mag)) ? cfg_max_mag : amag[pdmc_pkg::MAG_W-1:0];
      b.raw  = quo[pdmc_pkg::SUM_W-1:0];
      last_meas = meas;
      return b;
   endfunction

   function automatic void apply_csr(logic [pdmc_pkg::CSR_IDX_W-1:0] idx,
                                     logic [pdmc_pkg::CSR_DAT_W-1:0] data);
      case (idx)
         pdmc_pkg::CSR_SET_POINT:     cfg_set_point  = data[pdmc_pkg::MEAS_W-1:0];
         pdmc_pkg::CSR_PROP_GAIN:     cfg_prop_gain  = data[pdmc_pkg::GAIN_W-1:0];
         pdmc_pkg::CSR_DERIV_GAIN:    cfg_deriv_gain = data[pdmc_pkg::GAIN_W-1:0];
         pdmc_pkg::CSR_DIVISOR:       cfg_divisor    = data[pdmc_pkg::DIV_W-1:0];
         pdmc_pkg::CSR_MAX_MAGNITUDE: cfg_max_mag    = data[pdmc_pkg::MAG_W-1:0];
         default: ;         // unused slots are dropped
      endcase
   endfunction

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------------
   // monitor: every beat is seen at the rising edge
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      drive_beat_type want;
      drive_beat_type got;
      if (reset) begin
         cfg_set_point  = '0;
         cfg_prop_gain  = '0;
         cfg_deriv_gain = '0;
         cfg_divisor    = 16'd1;
         cfg_max_mag    = MAG_ALL_ONES;
         last_meas      = '0;
      end else begin
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_data);
         if (rsp_valid && rsp_ready) begin
            if (drive_due_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected response beat, magnitude %0d raw %0d",
                                       rsp_drive_magnitude, rsp_raw_drive));
            end else begin
               want = drive_due_q.pop_front();
               if (rsp_drive_magnitude !== want.mag)
                  flag_mismatch($sformatf("drive_magnitude %0d, wanted %0d",
                                          rsp_drive_magnitude, want.mag));
               if (rsp_raw_drive !== want.raw)
                  flag_mismatch($sformatf("raw_drive %0d, wanted %0d",
                                          rsp_raw_drive, want.raw));
            end
         end
         if (req_valid && req_ready) begin
            // the law is always run so the stored sample stays in step
            got = predict_drive(req_measurement);
            drive_due_q.push_back(beat_typed ? beat_want : got);
         end
      end
   end

   // watchdog on a run with no beats at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver back-pressure, none at all during the calm phase
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void add_csr(logic [pdmc_pkg::CSR_IDX_W-1:0] idx,
                                   logic [pdmc_pkg::CSR_DAT_W-1:0] data);
      stim_row_type r;
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.data  = data;
      r.meas  = '0;
      r.typed = 1'b0;
      r.want  = '0;
      dir_rows.push_back(r);
   endfunction

   function automatic void add_sample(logic signed [pdmc_pkg::MEAS_W-1:0] meas, bit typed,
                                      logic [pdmc_pkg::MAG_W-1:0] mag,
                                      logic signed [pdmc_pkg::SUM_W-1:0] raw);
      stim_row_type r;
      r.kind     = ROW_SAMPLE;
      r.idx      = '0;
      r.data     = '0;
      r.meas     = meas;
      r.typed    = typed;
      r.want.mag = mag;
      r.want.raw = raw;
      dir_rows.push_back(r);
   endfunction

   function automatic logic [pdmc_pkg::CSR_DAT_W-1:0] wide_random();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[pdmc_pkg::CSR_DAT_W-1:0];
   endfunction

   // gains and set point: extremes, small values near unity, or anything
   function automatic logic [15:0] pick_word();
      logic [15:0] w;
      case ($urandom_range(5))
         0:       w = 16'h8000;
         1:       w = 16'h7fff;
         2:       w = 16'($urandom_range(768));
         3:       w = -16'($urandom_range(768));
         default: w = 16'($urandom());
      endcase
      return w;
   endfunction

   function automatic logic [pdmc_pkg::DIV_W-1:0] pick_divisor();
      logic [pdmc_pkg::DIV_W-1:0] w;
      case ($urandom_range(4))
         0:       w = '0;
         1:       w = 16'd1;
         2:       w = '1;
         3:       w = 16'($urandom_range(16, 2));
         default: w = 16'($urandom_range(65535, 1));
      endcase
      return w;
   endfunction

   function automatic logic [pdmc_pkg::MAG_W-1:0] pick_limit();
      logic [pdmc_pkg::MAG_W-1:0] w;
      case ($urandom_range(3))
         0:       w = '0;
         1:       w = MAG_ALL_ONES;
         2:       w = 33'($urandom_range(1 << 20));
         default: w = wide_random();
      endcase
      return w;
   endfunction

   // half the time a slow wander like a real sensor, with jumps and extremes mixed in
   function automatic logic signed [pdmc_pkg::MEAS_W-1:0] next_meas(
         logic signed [pdmc_pkg::MEAS_W-1:0] prev);
      int d;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       return 16'sh8000;
               1:       return 16'sh7fff;
               2:       return 16'sh0000;
               default: return -16'sd1;
            endcase
         end
         1, 2, 3, 4: return 16'($urandom());
         default: begin
            d = int'($urandom_range(600)) - 300;
            return 16'(prev + d);
         end
      endcase
   endfunction

   // one request beat; valid stays up across back-to-back beats
   task automatic send_sample(logic signed [pdmc_pkg::MEAS_W-1:0] meas, bit typed,
                              drive_beat_type want);
      int unsigned n;
      n = 0;
      if (!calm) begin
         // now and then a long gap so arrivals land on every cycle of the divider
         if ($urandom_range(7) == 0)
            n = $urandom_range(45, 1);
         else
            while ($urandom_range(99) < IDLE_PCT) n++;
      end
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_measurement <= meas;
      beat_typed      <= typed;
      beat_want       <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off until every response has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_due_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [pdmc_pkg::CSR_IDX_W-1:0] idx,
                            logic [pdmc_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // new settings for one random phase; upper data bits are junk for narrow registers
   task automatic retune(int unsigned ph);
      logic [pdmc_pkg::CSR_DAT_W-1:0] d;
      d = wide_random();
      d[15:0] = (ph == 0) ? 16'h7fff : (ph == 1) ? 16'h8000 : pick_word();
      write_csr(pdmc_pkg::CSR_SET_POINT, d);
      d = wide_random();
      d[15:0] = (ph == 0) ? 16'h7fff : (ph == 1) ? 16'h8000 : pick_word();
      write_csr(pdmc_pkg::CSR_PROP_GAIN, d);
      d = wide_random();
      d[15:0] = (ph == 0) ? 16'h7fff : (ph == 1) ? 16'h8000 : pick_word();
      write_csr(pdmc_pkg::CSR_DERIV_GAIN, d);
      d = wide_random();
      d[15:0] = (ph == 0) ? 16'd1 : (ph == 1) ? 16'hffff : pick_divisor();
      write_csr(pdmc_pkg::CSR_DIVISOR, d);
      d = (ph == 0) ? MAG_ALL_ONES : (ph == 1) ? '0 : pick_limit();
      write_csr(pdmc_pkg::CSR_MAX_MAGNITUDE, d);
      if ($urandom_range(2) == 0)
         write_csr(3'($urandom_range(CSR_LAST_SLOT, CSR_PAST_END)), wide_random());
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic signed [pdmc_pkg::MEAS_W-1:0] walk;
      drive_beat_type                     none_due;
      none_due = '0;
      walk     = '0;

      // straight after reset both gains are zero, so the drive is zero
      add_sample(16'sd0,      1'b1, 33'd0, 34'sd0);
      add_sample(16'sh7fff,   1'b1, 33'd0, 34'sd0);
      add_sample(16'sh8000,   1'b1, 33'd0, 34'sd0);
      // unity proportional gain, set point zero: drive is -256 * |m|
      add_csr(pdmc_pkg::CSR_PROP_GAIN, 33'd256);
      add_sample(16'sd100,    1'b1, 33'd25600, -34'sd25600);
      add_sample(-16'sd100,   1'b1, 33'd25600, -34'sd25600);
      // clamp at zero leaves the raw drive alone
      add_csr(pdmc_pkg::CSR_MAX_MAGNITUDE, 33'd0);
      add_sample(16'sd7,      1'b1, 33'd0, -34'sd1792);
      add_csr(pdmc_pkg::CSR_MAX_MAGNITUDE, MAG_ALL_ONES);
      // largest weighted sums, both signs
      add_csr(pdmc_pkg::CSR_SET_POINT,  33'h0_0000_7fff);
      add_csr(pdmc_pkg::CSR_PROP_GAIN,  33'h0_0000_7fff);
      add_csr(pdmc_pkg::CSR_DERIV_GAIN, 33'h0_0000_8000);
      add_sample(16'sh8000,   1'b0, '0, '0);
      add_sample(16'sh7fff,   1'b0, '0, '0);
      add_sample(16'sh8000,   1'b0, '0, '0);
      add_sample(16'sd0,      1'b0, '0, '0);
      add_csr(pdmc_pkg::CSR_SET_POINT,  33'h1_ffff_8000);
      add_csr(pdmc_pkg::CSR_PROP_GAIN,  33'h1_5555_8000);
      add_csr(pdmc_pkg::CSR_DERIV_GAIN, 33'h1_aaaa_7fff);
      add_sample(16'sh7fff,   1'b0, '0, '0);
      add_sample(16'sh8000,   1'b0, '0, '0);
      add_sample(16'sh7fff,   1'b0, '0, '0);
      // zero divisor passes the sum straight through
      add_csr(pdmc_pkg::CSR_DIVISOR, 33'd0);
      add_sample(16'sd5,      1'b0, '0, '0);
      add_sample(-16'sd5,     1'b0, '0, '0);
      add_csr(pdmc_pkg::CSR_DIVISOR, 33'h0_0000_ffff);
      add_sample(16'sh8000,   1'b0, '0, '0);
      add_sample(16'sd12345,  1'b0, '0, '0);
      // small odd divisor, truncation toward zero on both signs
      add_csr(pdmc_pkg::CSR_DIVISOR,    33'd7);
      add_csr(pdmc_pkg::CSR_PROP_GAIN,  33'd256);
      add_csr(pdmc_pkg::CSR_DERIV_GAIN, 33'd0);
      add_csr(pdmc_pkg::CSR_SET_POINT,  33'd10);
      add_sample(-16'sd1,     1'b0, '0, '0);
      add_sample(16'sd30,     1'b0, '0, '0);
      // writes past the register list must change nothing
      add_csr(CSR_PAST_END,  MAG_ALL_ONES);
      add_csr(CSR_LAST_SLOT, 33'd0);
      add_sample(16'sd3,      1'b0, '0, '0);
      add_csr(pdmc_pkg::CSR_MAX_MAGNITUDE, 33'd1000);
      add_sample(16'sh7fff,   1'b0, '0, '0);
      add_sample(16'sh8000,   1'b0, '0, '0);
      add_csr(pdmc_pkg::CSR_MAX_MAGNITUDE, MAG_ALL_ONES);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain();
            write_csr(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_sample(dir_rows[i].meas, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // random phases, each under fresh settings written while idle
      for (int unsigned ph = 0; ph < PHASES; ph++) begin
         drain();
         calm = (ph == CALM_PHASE);
         retune(ph);
         for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) == 0)
               drain();
            walk = next_meas(walk);
            send_sample(walk, 1'b0, none_due);
         end
      end
      calm = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/pdmc_pkg.sv
hw/rtl/pdmc_divider.sv
hw/rtl/pd_drive_magnitude_clamp.sv
dv/tb.sv
